// ===== hdl/rodcut_pkg.sv =====
// shared constants, types and helpers for the rod cutting solver
package rodcut_pkg;

  localparam int MAX_LENGTH = 32;
  localparam int MAX_PIECES = 32;
  localparam int PRICE_BITS = 16;

  // fixed field widths of the channels
  localparam int KIND_W      = 2;
  localparam int SIZE_W      = 6;
  localparam int PRICE_IN_W  = 16;
  localparam int TGT_W       = 6;
  localparam int VALUE_W     = 21;

  // derived widths
  localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
  localparam int PIDX_W    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CNT_W     = $clog2(MAX_PIECES + 1);
  localparam int REV_W     = PRICE_BITS + LEN_W;
  localparam int MEM_DEPTH = MAX_LENGTH + 1;
  localparam int EXT_W     = REV_W + VALUE_W;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd2;

  // result kinds
  localparam logic RES_REVENUE = 1'b0;
  localparam logic RES_CUT     = 1'b1;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // one entry of the best-revenue table: cut taken last and best revenue
  typedef struct packed {
    logic [LEN_W-1:0] cut;
    logic [REV_W-1:0] rev;
  } dp_entry_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic latch_solve;
    logic init;
    logic issue;
    logic len_next;
    logic fetch;
    logic emit_rev;
    logic cut_rd;
    logic emit_cut;
  } dp_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic target_zero;
    logic len_at_target;
    logic out_free;
    logic has_cuts;
    logic cut_final;
  } dp_status_t;

  function automatic logic [VALUE_W-1:0] sat_value(input logic [REV_W-1:0] r);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(r);
    if (ext > EXT_W'(VALUE_MAX)) begin
      return VALUE_MAX;
    end
    return ext[VALUE_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] sat_target(input logic [TGT_W-1:0] t);
    if (t > TGT_W'(MAX_LENGTH)) begin
      return LEN_W'(MAX_LENGTH);
    end
    return t[LEN_W-1:0];
  endfunction

endpackage

// ===== hdl/rodcut_if.sv =====
// item channels of the rod cutting solver
interface rodcut_in_if;
  logic                                valid;
  logic                                ready;
  logic [rodcut_pkg::KIND_W-1:0]       kind;
  logic [rodcut_pkg::SIZE_W-1:0]       piece_size;
  logic [rodcut_pkg::PRICE_IN_W-1:0]   piece_price;
  logic [rodcut_pkg::TGT_W-1:0]        target_length;
  logic                                show_cuts;

  modport source (output valid, kind, piece_size, piece_price, target_length, show_cuts,
                  input ready);
  modport sink (input valid, kind, piece_size, piece_price, target_length, show_cuts,
                output ready);
endinterface

interface rodcut_out_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [rodcut_pkg::VALUE_W-1:0]   value;
  logic                             last;

  modport source (output valid, result_kind, value, last, input ready);
  modport sink (input valid, result_kind, value, last, output ready);
endinterface

// ===== hdl/rodcut_ctrl.sv =====
// sequencing state machine of the rod cutting solver
module rodcut_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rodcut_pkg::KIND_W-1:0] in_kind,
  input  rodcut_pkg::dp_status_t        status,
  output logic                          in_ready,
  output rodcut_pkg::dp_cmd_t           cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INIT     = 9'b000000010,
    S_PIECE    = 9'b000000100,
    S_DRAIN    = 9'b000001000,
    S_WRITE    = 9'b000010000,
    S_FETCH    = 9'b000100000,
    S_REV      = 9'b001000000,
    S_CUT_RD   = 9'b010000000,
    S_CUT_EMIT = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == rodcut_pkg::KIND_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (in_kind == rodcut_pkg::KIND_ADD) begin
            cmd.add = 1'b1;
          end else if (in_kind == rodcut_pkg::KIND_SOLVE) begin
            cmd.latch_solve = 1'b1;
            state_nxt       = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = status.target_zero ? S_FETCH : S_PIECE;
      end
      S_PIECE: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.len_next = 1'b1;
        state_nxt    = status.len_at_target ? S_FETCH : S_PIECE;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_REV;
      end
      S_REV: begin
        if (status.out_free) begin
          cmd.emit_rev = 1'b1;
          state_nxt    = status.has_cuts ? S_CUT_RD : S_IDLE;
        end
      end
      S_CUT_RD: begin
        cmd.cut_rd = 1'b1;
        state_nxt  = S_CUT_EMIT;
      end
      S_CUT_EMIT: begin
        if (status.out_free) begin
          cmd.emit_cut = 1'b1;
          state_nxt    = status.cut_final ? S_IDLE : S_CUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/rodcut_dp.sv =====
// piece table, best-revenue memory, compare-add pipeline and result register
module rodcut_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rodcut_pkg::dp_cmd_t               cmd,
  input  logic [rodcut_pkg::SIZE_W-1:0]     in_piece_size,
  input  logic [rodcut_pkg::PRICE_IN_W-1:0] in_piece_price,
  input  logic [rodcut_pkg::TGT_W-1:0]      in_target_length,
  input  logic                              in_show_cuts,
  input  logic                              out_ready,
  output rodcut_pkg::dp_status_t            status,
  output logic                              out_valid,
  output logic                              out_result_kind,
  output logic [rodcut_pkg::VALUE_W-1:0]    out_value,
  output logic                              out_last
);

  // piece table
  logic [rodcut_pkg::LEN_W-1:0]      size_tab  [rodcut_pkg::MAX_PIECES];
  logic [rodcut_pkg::PRICE_BITS-1:0] price_tab [rodcut_pkg::MAX_PIECES];
  logic [rodcut_pkg::CNT_W-1:0]      count_r;

  // solve control
  logic [rodcut_pkg::LEN_W-1:0] target_r;
  logic                         show_r;
  logic [rodcut_pkg::LEN_W-1:0] len_r;
  logic [rodcut_pkg::CNT_W-1:0] p_r;
  logic [rodcut_pkg::REV_W-1:0] best_r;
  logic [rodcut_pkg::LEN_W-1:0] cut_r;
  logic [rodcut_pkg::LEN_W-1:0] n_r;
  logic [rodcut_pkg::LEN_W-1:0] cur_cut_r;

  // second pipeline stage
  logic                              s1_valid_r;
  logic [rodcut_pkg::PRICE_BITS-1:0] s1_price_r;
  logic [rodcut_pkg::LEN_W-1:0]      s1_size_r;

  // best-revenue memory
  rodcut_pkg::dp_entry_t        dp_mem [rodcut_pkg::MEM_DEPTH];
  rodcut_pkg::dp_entry_t        rd_r;
  rodcut_pkg::dp_entry_t        mem_wdata;
  logic [rodcut_pkg::LEN_W-1:0] mem_waddr;
  logic [rodcut_pkg::LEN_W-1:0] mem_raddr;
  logic                         mem_we;
  logic                         rd_en;

  // output register
  logic                           out_valid_r;
  logic                           out_kind_r;
  logic [rodcut_pkg::VALUE_W-1:0] out_value_r;
  logic                           out_last_r;

  logic [rodcut_pkg::PIDX_W-1:0] p_idx;
  logic [rodcut_pkg::LEN_W-1:0]  sz0;
  logic                          fit0;
  logic                          s0_ok;
  logic [rodcut_pkg::REV_W-1:0]  cand;
  logic                          add_ok;
  logic                          out_load;

  // first stage: pick a piece and address the remainder
  assign p_idx = p_r[rodcut_pkg::PIDX_W-1:0];
  assign sz0   = size_tab[p_idx];
  assign fit0  = (sz0 <= len_r);
  assign s0_ok = cmd.issue && (p_r < count_r) && fit0;

  assign add_ok = cmd.add && (in_piece_size != '0)
                  && (in_piece_size <= rodcut_pkg::SIZE_W'(rodcut_pkg::MAX_LENGTH))
                  && (count_r < rodcut_pkg::CNT_W'(rodcut_pkg::MAX_PIECES));

  always_comb begin
    mem_raddr = '0;
    if (cmd.issue) begin
      mem_raddr = fit0 ? (len_r - sz0) : '0;
    end else if (cmd.fetch) begin
      mem_raddr = target_r;
    end else if (cmd.cut_rd) begin
      mem_raddr = n_r - cur_cut_r;
    end
  end
  assign rd_en = cmd.issue || cmd.fetch || cmd.cut_rd;

  assign mem_we    = cmd.init || cmd.len_next;
  assign mem_waddr = cmd.init ? '0 : len_r;
  always_comb begin
    mem_wdata = '0;
    if (cmd.len_next) begin
      mem_wdata.cut = cut_r;
      mem_wdata.rev = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dp_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_r <= dp_mem[mem_raddr];
    end
  end

  // piece table writes
  always_ff @(posedge clk) begin
    if (add_ok) begin
      size_tab[count_r[rodcut_pkg::PIDX_W-1:0]]  <= in_piece_size[rodcut_pkg::LEN_W-1:0];
      price_tab[count_r[rodcut_pkg::PIDX_W-1:0]] <= in_piece_price[rodcut_pkg::PRICE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (add_ok) begin
      count_r <= count_r + 1'b1;
    end
  end

  // second stage: compare-add against the running best
  assign cand = rd_r.rev + rodcut_pkg::REV_W'(s1_price_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_ok;
    end
  end

  always_ff @(posedge clk) begin
    s1_price_r <= price_tab[p_idx];
    s1_size_r  <= sz0;
    if (cmd.latch_solve) begin
      target_r <= rodcut_pkg::sat_target(in_target_length);
      show_r   <= in_show_cuts;
    end
    if (cmd.init) begin
      len_r  <= rodcut_pkg::LEN_W'(1);
      p_r    <= '0;
      best_r <= '0;
      cut_r  <= '0;
    end else if (cmd.len_next) begin
      len_r  <= len_r + 1'b1;
      p_r    <= '0;
      best_r <= '0;
      cut_r  <= '0;
    end else begin
      if (cmd.issue) begin
        p_r <= p_r + 1'b1;
      end
      if (s1_valid_r && (cand > best_r)) begin
        best_r <= cand;
        cut_r  <= s1_size_r;
      end
    end
    if (cmd.emit_rev) begin
      cur_cut_r <= rd_r.cut;
      n_r       <= target_r;
    end else if (cmd.cut_rd) begin
      n_r <= n_r - cur_cut_r;
    end else if (cmd.emit_cut) begin
      cur_cut_r <= rd_r.cut;
    end
  end

  // result register
  assign out_load = cmd.emit_rev || cmd.emit_cut;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rev) begin
      out_kind_r  <= rodcut_pkg::RES_REVENUE;
      out_value_r <= rodcut_pkg::sat_value(rd_r.rev);
      out_last_r  <= !status.has_cuts;
    end else if (cmd.emit_cut) begin
      out_kind_r  <= rodcut_pkg::RES_CUT;
      out_value_r <= rodcut_pkg::VALUE_W'(cur_cut_r);
      out_last_r  <= status.cut_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_value       = out_value_r;
  assign out_last        = out_last_r;

  assign status.last_issue    = ({1'b0, p_r} + 1'b1) >= {1'b0, count_r};
  assign status.target_zero   = (target_r == '0);
  assign status.len_at_target = (len_r == target_r);
  assign status.out_free      = !out_valid_r || out_ready;
  assign status.has_cuts      = show_r && (rd_r.cut != '0);
  assign status.cut_final     = (rd_r.cut == '0);

endmodule

// ===== hdl/rod_cutting_max_revenue.sv =====
// top level of the rod cutting solver: channels, controller and datapath
// Rod cutting (unbounded knapsack) solver. Clear and add items load a piece
// table of up to 32 pieces; a piece of size zero, longer than 32 or beyond
// a full table is dropped, as is kind 3. A solve item fills the best-revenue
// table for lengths 1 up to its target (saturated at 32) and returns the
// maximum revenue, then, when show_cuts is set, the cut sizes walked back
// from the end of the rod; last marks the final result. The fill runs one
// piece per cycle through a two-stage compare-add pipeline around a
// single-port best-revenue memory; each length, even one with no pieces,
// ends with a drain and a write-back step, and each result waits for the
// output register to be free. The next item is accepted as soon as the last
// result of a solve is in the output register; a new item waits while a
// solve is running.
module rod_cutting_max_revenue (
  input logic        clk,
  input logic        rst_n,
  rodcut_in_if.sink  in_ch,
  rodcut_out_if.source out_ch
);

  rodcut_pkg::dp_cmd_t    cmd;
  rodcut_pkg::dp_status_t status;

  // state machine: decodes items, steps lengths and pieces, walks the cuts
  rodcut_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .status   (status),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // piece table, revenue memory, compare-add stages and output register
  rodcut_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_piece_size    (in_ch.piece_size),
    .in_piece_price   (in_ch.piece_price),
    .in_target_length (in_ch.target_length),
    .in_show_cuts     (in_ch.show_cuts),
    .out_ready        (out_ch.ready),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_result_kind  (out_ch.result_kind),
    .out_value        (out_ch.value),
    .out_last         (out_ch.last)
  );

`ifndef NO_ASSERTIONS
  // a result is only loaded when the output register can take it
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rev || cmd.emit_cut) |-> status.out_free)
    else $error("result loaded over a pending item");

  // an accepted solve blocks the input side on the next cycle
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.kind == rodcut_pkg::KIND_SOLVE))
    |=> !in_ch.ready)
    else $error("input taken while a solve runs");

  // a cut item never carries a zero size
  a_cut_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.result_kind == rodcut_pkg::RES_CUT)) |-> (out_ch.value != '0))
    else $error("zero cut size emitted");
`endif

endmodule

// ===== tb/sv/rodcut_revenue_checker.sv =====
// checker for the rod cutting solver: predicts revenue and cut items and compares them
`timescale 1ns / 100ps

module rodcut_revenue_checker
  import rodcut_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [SIZE_W-1:0]     in_piece_size,
  input  logic [PRICE_IN_W-1:0] in_piece_price,
  input  logic [TGT_W-1:0]      in_target_length,
  input  logic                  in_show_cuts,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_result_kind,
  input  logic [VALUE_W-1:0]    out_value,
  input  logic                  out_last,
  output int                    mismatch_count,
  output int                    pending_results
);

  typedef struct packed {
    logic               result_kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } rod_result_t;

  // own copy of the piece table
  logic [SIZE_W-1:0]     piece_sizes  [MAX_PIECES];
  logic [PRICE_BITS-1:0] piece_prices [MAX_PIECES];
  int                    piece_total;

  rod_result_t expected_results [$];
  rod_result_t seen_result;
  rod_result_t oldest_result;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    piece_total     = 0;
  end

  task automatic predict_item(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
                              input logic [PRICE_IN_W-1:0] price,
                              input logic [TGT_W-1:0] target, input logic show);
    logic [REV_W-1:0]  best   [0:MAX_LENGTH];
    logic [SIZE_W-1:0] cut_at [0:MAX_LENGTH];
    bit                fitted [0:MAX_LENGTH];
    logic [SIZE_W-1:0] cuts   [$];
    logic [REV_W-1:0]  cand;
    rod_result_t       res;
    int                length;
    int                rest;
    case (kind)
      KIND_CLEAR: begin
        piece_total = 0;
      end
      KIND_ADD: begin
        if (size != 0 && size <= MAX_LENGTH && piece_total < MAX_PIECES) begin
          piece_sizes[piece_total]  = size;
          piece_prices[piece_total] = PRICE_BITS'(price);
          piece_total++;
        end
      end
      KIND_SOLVE: begin
        length    = (target > MAX_LENGTH) ? MAX_LENGTH : int'(target);
        best[0]   = '0;
        cut_at[0] = '0;
        fitted[0] = 1'b0;
        for (int len = 1; len <= length; len++) begin
          best[len]   = '0;
          cut_at[len] = '0;
          fitted[len] = 1'b0;
          // strict compare: on a tie the earlier piece stays
          for (int p = 0; p < piece_total; p++) begin
            if (piece_sizes[p] <= len) begin
              cand = best[len - piece_sizes[p]] + REV_W'(piece_prices[p]);
              if (cand > best[len]) begin
                best[len]   = cand;
                cut_at[len] = piece_sizes[p];
                fitted[len] = 1'b1;
              end
            end
          end
        end
        // walk back from the end, stopping at a length no piece fitted
        rest = length;
        if (show) begin
          while (rest > 0 && fitted[rest] && cuts.size() < MAX_LENGTH) begin
            if (cut_at[rest] == 0 || cut_at[rest] > rest) break;
            cuts.push_back(cut_at[rest]);
            rest -= cut_at[rest];
          end
        end
        res.result_kind = RES_REVENUE;
        res.value = (best[length] > REV_W'(VALUE_MAX)) ? VALUE_MAX : best[length][VALUE_W-1:0];
        res.last  = (cuts.size() == 0);
        expected_results.push_back(res);
        for (int k = 0; k < cuts.size(); k++) begin
          res.result_kind = RES_CUT;
          res.value       = VALUE_W'(cuts[k]);
          res.last        = (k == cuts.size() - 1);
          expected_results.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      piece_total = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_kind, in_piece_size, in_piece_price, in_target_length, in_show_cuts);
      end
      if (out_valid && out_ready) begin
        seen_result = '{out_result_kind, out_value, out_last};
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected item: kind %0d value %0d last %0d",
                     seen_result.result_kind, seen_result.value, seen_result.last);
          end
          mismatch_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (seen_result !== oldest_result) begin
            if (mismatch_count < 10) begin
              $display("mismatch: expected kind %0d value %0d last %0d, got kind %0d value %0d last %0d",
                       oldest_result.result_kind, oldest_result.value, oldest_result.last,
                       seen_result.result_kind, seen_result.value, seen_result.last);
            end
            mismatch_count++;
          end
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== tb/sv/rod_cutting_max_revenue_test.sv =====
// top of the rod cutting solver testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module rod_cutting_max_revenue_test;
  import rodcut_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 420;
  // receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES    = 1500;
  // the hold-off is the longest quiet stretch
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1200;

  // kind that the block drops
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  rodcut_in_if  in_ch ();
  rodcut_out_if out_ch ();

  int mismatch_count;
  int pending_results;

  // idling knobs, written only by the stimulus process; idle_cycles is the watchdog's counter
  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_requests;
  int useful_items;
  int idle_cycles;

  rod_cutting_max_revenue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rodcut_revenue_checker checker_inst (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_kind          (in_ch.kind),
    .in_piece_size    (in_ch.piece_size),
    .in_piece_price   (in_ch.piece_price),
    .in_target_length (in_ch.target_length),
    .in_show_cuts     (in_ch.show_cuts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_kind  (out_ch.result_kind),
    .out_value        (out_ch.value),
    .out_last         (out_ch.last),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks
  initial begin : receiver
    int hold_served;
    hold_served  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served  = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // watchdog: cycles in a row with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one item from a falling edge, return at the falling edge after it is taken
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
                           input logic [PRICE_IN_W-1:0] price,
                           input logic [TGT_W-1:0] target, input logic show);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.piece_size    <= size;
    in_ch.piece_price   <= price;
    in_ch.target_length <= target;
    in_ch.show_cuts     <= show;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // well-formed items carry random junk in the fields they do not use
  task automatic clear_pieces();
    send_item(KIND_CLEAR, SIZE_W'($urandom), PRICE_IN_W'($urandom), TGT_W'($urandom),
              1'($urandom));
    useful_items++;
  endtask

  task automatic load_piece(input int size, input int price);
    send_item(KIND_ADD, SIZE_W'(size), PRICE_IN_W'(price), TGT_W'($urandom), 1'($urandom));
    useful_items++;
  endtask

  task automatic solve_rod(input int target, input logic show);
    send_item(KIND_SOLVE, SIZE_W'($urandom), PRICE_IN_W'($urandom), TGT_W'(target), show);
    useful_items++;
  endtask

  task automatic wait_results_drained();
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int pick;
    int pieces;
    int solves;
    int noise_goal;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_CLEAR;
    in_ch.piece_size    = '0;
    in_ch.piece_price   = '0;
    in_ch.target_length = '0;
    in_ch.show_cuts     = 1'b0;
    sender_idle_pct     = 15;
    receiver_idle_pct   = 49;
    hold_requests       = 0;
    useful_items        = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    solve_rod(0, 1'b1);                     // zero target
    solve_rod(7, 1'b1);                     // empty piece table
    send_item(KIND_ADD, 6'd0, 16'd100, '0, 1'b0);         // zero size dropped
    send_item(KIND_ADD, 6'd33, 16'd100, '1, 1'b1);        // just past the longest rod
    send_item(KIND_ADD, 6'd63, 16'hffff, '1, 1'b1);       // widest size field
    send_item(KIND_UNUSED, SIZE_W'($urandom), PRICE_IN_W'($urandom), TGT_W'($urandom),
              1'b1);                        // unknown kind
    load_piece(1, 0);                       // zero price never beats zero revenue
    solve_rod(5, 1'b1);
    clear_pieces();
    load_piece(3, 7);
    solve_rod(4, 1'b1);                     // walk stops at an unfitted length
    solve_rod(2, 1'b0);                     // nothing fits at all
    clear_pieces();
    load_piece(2, 10);
    load_piece(1, 5);
    solve_rod(6, 1'b1);                     // tie: the size-2 piece came first
    clear_pieces();
    load_piece(1, 5);
    load_piece(2, 10);
    solve_rod(6, 1'b1);                     // same tie, other order
    clear_pieces();
    load_piece(1, 65535);
    load_piece(32, 65535);
    solve_rod(63, 1'b1);                    // saturated target, top revenue, 32 cuts
    solve_rod(40, 1'b0);

    // back-pressure: stall the receiver while solves keep coming, then drain
    clear_pieces();
    load_piece(1, 3);
    load_piece(2, 7);
    hold_requests++;
    repeat (10) solve_rod($urandom_range(1, 8), 1'b1);
    in_ch.valid <= 1'b0;
    wait_results_drained();

    // random part, in three idling phases
    noise_goal = useful_items + RANDOM_ITEMS;
    while (useful_items < noise_goal) begin
      if (useful_items < noise_goal - (2 * RANDOM_ITEMS) / 3) begin
        sender_idle_pct   = 15;
        receiver_idle_pct = 49;
      end else if (useful_items < noise_goal - RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 49;
        receiver_idle_pct = 15;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // noise: items the block drops
        case ($urandom_range(0, 2))
          0: send_item(KIND_UNUSED, SIZE_W'($urandom), PRICE_IN_W'($urandom),
                       TGT_W'($urandom), 1'($urandom));
          1: send_item(KIND_ADD, 6'd0, PRICE_IN_W'($urandom), TGT_W'($urandom),
                       1'($urandom));
          default: send_item(KIND_ADD, SIZE_W'($urandom_range(33, 63)), PRICE_IN_W'($urandom),
                             TGT_W'($urandom), 1'($urandom));
        endcase
      end else begin
        // well-formed: mostly a fresh table, a few pieces, then some solves
        if ($urandom_range(0, 3) != 0) clear_pieces();
        pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 8);
        repeat (pieces) begin
          load_piece(($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 12),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535));
        end
        solves = $urandom_range(1, 3);
        repeat (solves) begin
          solve_rod(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16),
                    ($urandom_range(0, 3) != 0));
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait_results_drained();
    // let any stray item show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
